// File: sv/maa_pkg.sv
// Package for the multichannel ADC averager: shared widths, codes and helpers.
// Used by the channel interfaces and by the averager top level.
// Depends on nothing.
package maa_pkg;

  // Payload widths of the channel interfaces and width of the filter enable field.
  localparam int DATA_W     = 16;
  localparam int CH_OUT_W   = 3;
  localparam int FILTER_W   = 8;

  // Default array sizes, handed to the top level as parameter defaults.
  localparam int NUM_CHANNELS_DEF = 8;
  localparam int AVG_DEPTH_DEF    = 8;

  // Configuration port geometry and register map.
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0] REG_FILTER_ENABLE_ADDR = 2'd0;

  // Store reset code and the two rail codes that count as stuck.
  localparam logic [DATA_W-1:0] MID_CODE = 16'h8000;
  localparam logic [DATA_W-1:0] CODE_MIN = 16'h0000;
  localparam logic [DATA_W-1:0] CODE_MAX = 16'hFFFF;

  // True when a code sits at either rail.
  function automatic logic code_stuck(logic [DATA_W-1:0] v);
    return (v == CODE_MIN) || (v == CODE_MAX);
  endfunction

endpackage

// File: sv/maa_if.sv
// Valid/ready channel interfaces for conversion beats and result beats.
// Depends on maa_pkg for the payload widths.

interface maa_in_if;
  import maa_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sample;
  logic              transfer_ok;
  logic              discard_next;

  modport source(output valid, sample, transfer_ok, discard_next, input ready);
  modport sink(input valid, sample, transfer_ok, discard_next, output ready);
endinterface

interface maa_out_if;
  import maa_pkg::*;
  logic                valid;
  logic                ready;
  logic [CH_OUT_W-1:0] channel;
  logic                accepted;
  logic [DATA_W-1:0]   raw_value;
  logic [DATA_W-1:0]   average;
  logic                stuck_fault;

  modport source(output valid, channel, accepted, raw_value, average, stuck_fault,
                 input ready);
  modport sink(input valid, channel, accepted, raw_value, average, stuck_fault,
               output ready);
endinterface

// File: sv/multichannel_adc_averager_unit.sv
// Multichannel ADC averager: round-robin channels with a moving average per channel.
// A beat steps through read, update, multiply and result; a filtered sample in
// the first pass adds a fill step that writes every slot through the store port.
// Only one beat is in flight: the single store port and the read-modify-write
// sequence hold one beat at a time. After reset a clear pass over all
// NUM_CHANNELS*AVG_DEPTH store slots sets the stores while in_beat.ready stays low.
module multichannel_adc_averager_unit #(
  parameter int NUM_CHANNELS = maa_pkg::NUM_CHANNELS_DEF,
  parameter int AVG_DEPTH    = maa_pkg::AVG_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  maa_in_if.sink                      in_beat,
  maa_out_if.source                   out_beat,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [maa_pkg::CFG_AW-1:0]  paddr,
  input  logic [maa_pkg::CFG_DW-1:0]  pwdata,
  output logic [maa_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import maa_pkg::*;

  localparam int CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SL_W     = $clog2(AVG_DEPTH);
  localparam int ST_DEPTH = NUM_CHANNELS * AVG_DEPTH;
  localparam int ST_AW    = $clog2(ST_DEPTH);
  localparam int SUM_W    = DATA_W + SL_W;
  localparam int SE_W     = DATA_W + SUM_W;
  localparam int PROD_W   = 2 * SUM_W + 1;
  // Reciprocal for an exact floor(sum / AVG_DEPTH) over every SUM_W-bit sum.
  localparam int DIV_K    = SUM_W + SL_W;
  localparam longint unsigned DIV_M =
    ((64'd1 << DIV_K) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
  localparam logic [SUM_W:0]   DIV_M_V   = (SUM_W + 1)'(DIV_M);
  localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(AVG_DEPTH * int'(MID_CODE));

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_CALC = 6'b000100,
    ST_FILL = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Clear pass after reset.
  logic             clearing_r;
  logic [ST_AW-1:0] clr_idx_r;

  // Configuration and sequence state.
  logic [FILTER_W-1:0]     fe_r;
  logic [CH_W-1:0]         cur_ch_r;
  logic [SL_W-1:0]         ws_r;
  logic                    first_r;
  logic                    pend_r;
  logic                    fault_r;
  logic [NUM_CHANNELS-1:0] ign_r;
  logic [NUM_CHANNELS-1:0] stuck_filt_r;
  logic [NUM_CHANNELS-1:0] stuck_raw_r;

  // Beat being worked on.
  logic [DATA_W-1:0] smp_r;
  logic              ok_r;
  logic              disc_r;
  logic [CH_W-1:0]   item_ch_r;
  logic [SL_W-1:0]   fill_idx_r;

  // Values carried from the update step to the result.
  logic              filt_r;
  logic              store_r;
  logic [SUM_W-1:0]  sum_sel_r;
  logic [DATA_W-1:0] slot_val_r;
  logic [DATA_W-1:0] raw_r;
  logic              acc_r;
  logic [PROD_W-1:0] prod_r;

  // Output register.
  logic                out_valid_r;
  logic [CH_OUT_W-1:0] out_ch_r;
  logic                out_acc_r;
  logic [DATA_W-1:0]   out_raw_r;
  logic [DATA_W-1:0]   out_avg_r;
  logic                out_fault_r;

  // Memory ports.
  logic              st_we, st_re;
  logic [ST_AW-1:0]  st_waddr, st_raddr;
  logic [DATA_W-1:0] st_wdata, st_rdata;
  logic              sm_we, sm_re;
  logic [CH_W-1:0]   sm_waddr, sm_raddr;
  logic [SE_W-1:0]   sm_wdata, sm_rdata;

  logic [NUM_CHANNELS-1:0] chan_filt;
  logic                    item_filt;
  logic                    do_store;
  logic                    do_fill;
  logic [SL_W-1:0]         slot_sel;
  logic [SUM_W-1:0]        old_sum;
  logic [DATA_W-1:0]       old_raw;
  logic [SUM_W-1:0]        new_sum;
  logic [DATA_W-1:0]       quot;
  logic [DATA_W-1:0]       avg_val;
  logic [NUM_CHANNELS-1:0] stuck_filt_nxt;
  logic [NUM_CHANNELS-1:0] stuck_eff;
  logic                    fault_nxt;
  logic                    in_take;
  logic                    out_load;
  logic                    cfg_wr;

  function automatic logic [ST_AW-1:0] st_addr(logic [CH_W-1:0] ch, logic [SL_W-1:0] sl);
    return ST_AW'(int'(ch) * AVG_DEPTH + int'(sl));
  endfunction

  // Sample store: NUM_CHANNELS rows of AVG_DEPTH slots.
  maa_ram #(.WIDTH(DATA_W), .DEPTH(ST_DEPTH)) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .re   (st_re),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

  // Per-channel entry: last stored raw sample and the sum of the channel's row.
  maa_ram #(.WIDTH(SE_W), .DEPTH(NUM_CHANNELS)) u_sums (
    .clk  (clk),
    .we   (sm_we),
    .waddr(sm_waddr),
    .wdata(sm_wdata),
    .re   (sm_re),
    .raddr(sm_raddr),
    .rdata(sm_rdata)
  );

  // Filter selection per channel; only the first FILTER_W channels have a bit.
  always_comb begin
    chan_filt = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (c < FILTER_W) begin
        chan_filt[c] = fe_r[c % FILTER_W];
      end
    end
  end

  // Decode of the current beat, stable from the read through the update.
  assign item_filt = chan_filt[item_ch_r];
  assign do_store  = ok_r && !pend_r && !ign_r[item_ch_r];
  assign do_fill   = do_store && item_filt && first_r;
  assign slot_sel  = (do_store && item_filt && !first_r) ? ws_r : '0;

  assign old_sum = sm_rdata[SUM_W-1:0];
  assign old_raw = sm_rdata[SE_W-1 -: DATA_W];
  assign new_sum = do_fill ? SUM_W'(smp_r) * SUM_W'(AVG_DEPTH)
                           : old_sum - SUM_W'(st_rdata) + SUM_W'(smp_r);

  // Store port: clear pass, single-slot update, or first-pass fill.
  always_comb begin
    st_we    = 1'b0;
    st_waddr = st_addr(item_ch_r, slot_sel);
    st_wdata = smp_r;
    priority if (clearing_r) begin
      st_we    = 1'b1;
      st_waddr = clr_idx_r;
      st_wdata = MID_CODE;
    end else if (state_r == ST_CALC && do_store && !do_fill) begin
      st_we = 1'b1;
    end else if (state_r == ST_FILL) begin
      st_we    = 1'b1;
      st_waddr = st_addr(item_ch_r, fill_idx_r);
    end else begin
      st_we = 1'b0;
    end
  end
  assign st_re    = (state_r == ST_READ);
  assign st_raddr = st_addr(item_ch_r, slot_sel);

  // Sum port: every channel entry cleared in the clear pass, then one update per stored sample.
  always_comb begin
    sm_we    = 1'b0;
    sm_waddr = item_ch_r;
    sm_wdata = {smp_r, new_sum};
    priority if (clearing_r) begin
      sm_we    = (int'(clr_idx_r) < NUM_CHANNELS);
      sm_waddr = CH_W'(clr_idx_r);
      sm_wdata = {{DATA_W{1'b0}}, SUM_RESET};
    end else if (state_r == ST_CALC && do_store) begin
      sm_we = 1'b1;
    end else begin
      sm_we = 1'b0;
    end
  end
  assign sm_re    = (state_r == ST_READ);
  assign sm_raddr = item_ch_r;

  // Average and fault check at the end of the beat.
  assign quot    = prod_r[DIV_K +: DATA_W];
  assign avg_val = filt_r ? quot : slot_val_r;

  // Stuck check: each stored sample updates its channel's filtered flag; fault is sticky.
  always_comb begin
    stuck_filt_nxt = stuck_filt_r;
    if (store_r) begin
      stuck_filt_nxt[item_ch_r] = code_stuck(quot);
    end
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      stuck_eff[c] = chan_filt[c] ? stuck_filt_nxt[c] : stuck_raw_r[c];
    end
    fault_nxt = fault_r | (&stuck_eff);
  end

  assign in_take  = in_beat.valid && in_beat.ready;
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_beat.ready);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_take) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_CALC;
      ST_CALC: state_nxt = do_fill ? ST_FILL : ST_MUL;
      ST_FILL: if (fill_idx_r == SL_W'(AVG_DEPTH - 1)) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_FIN;
      ST_FIN:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      clearing_r   <= 1'b1;
      clr_idx_r    <= '0;
      fe_r         <= '0;
      cur_ch_r     <= '0;
      ws_r         <= '0;
      first_r      <= 1'b1;
      pend_r       <= 1'b0;
      fault_r      <= 1'b0;
      ign_r        <= '0;
      stuck_filt_r <= '0;
      stuck_raw_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Clear pass.
      if (clearing_r) begin
        if (clr_idx_r == ST_AW'(ST_DEPTH - 1)) begin
          clearing_r <= 1'b0;
        end else begin
          clr_idx_r <= clr_idx_r + 1'b1;
        end
      end

      // Configuration write.
      if (cfg_wr) begin
        fe_r <= pwdata[FILTER_W-1:0];
      end

      // Sequence update once the memories have been read.
      if (state_r == ST_CALC) begin
        priority if (!ok_r) begin
          pend_r <= 1'b1;
        end else if (pend_r) begin
          pend_r   <= 1'b0;
          cur_ch_r <= '0;
        end else begin
          // A set flag is cleared first, so the new flag is the request bit.
          ign_r[item_ch_r] <= disc_r;
          if (do_store && slot_sel == '0) begin
            stuck_raw_r[item_ch_r] <= code_stuck(smp_r);
          end
          if (item_ch_r == CH_W'(NUM_CHANNELS - 1)) begin
            cur_ch_r <= '0;
            ws_r     <= (ws_r == SL_W'(AVG_DEPTH - 1)) ? '0 : ws_r + 1'b1;
            first_r  <= 1'b0;
          end else begin
            cur_ch_r <= item_ch_r + 1'b1;
          end
        end
      end

      // Result register and sticky fault.
      if (out_load) begin
        stuck_filt_r <= stuck_filt_nxt;
        fault_r      <= fault_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_beat.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      smp_r     <= in_beat.sample;
      ok_r      <= in_beat.transfer_ok;
      disc_r    <= in_beat.discard_next;
      item_ch_r <= cur_ch_r;
    end
    if (state_r == ST_CALC) begin
      filt_r     <= item_filt;
      store_r    <= do_store;
      sum_sel_r  <= do_store ? new_sum : old_sum;
      slot_val_r <= do_store ? smp_r : st_rdata;
      raw_r      <= do_store ? smp_r : old_raw;
      acc_r      <= do_store;
      fill_idx_r <= '0;
    end
    if (state_r == ST_FILL) begin
      fill_idx_r <= fill_idx_r + 1'b1;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(sum_sel_r) * PROD_W'(DIV_M_V);
    end
    if (out_load) begin
      out_ch_r    <= CH_OUT_W'(item_ch_r);
      out_acc_r   <= acc_r;
      out_raw_r   <= raw_r;
      out_avg_r   <= avg_val;
      out_fault_r <= fault_nxt;
    end
  end

  // Handshake and result ports.
  assign in_beat.ready        = (state_r == ST_IDLE) && !clearing_r;
  assign out_beat.valid       = out_valid_r;
  assign out_beat.channel     = out_ch_r;
  assign out_beat.accepted    = out_acc_r;
  assign out_beat.raw_value   = out_raw_r;
  assign out_beat.average     = out_avg_r;
  assign out_beat.stuck_fault = out_fault_r;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_FILTER_ENABLE_ADDR);
  assign prdata = (paddr == REG_FILTER_ENABLE_ADDR) ? CFG_DW'(fe_r) : '0;

endmodule

// File: sv/maa_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Self-contained; used for the sample store and the per-channel sum store.
module maa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
